/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define BFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// Best-fit allocator package
// Shared widths, codes, types and parameter defaults.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Field widths.
  localparam int LEN_W  = 21;
  localparam int ADDR_W = 20;
  localparam int SLOT_W = 5;
  localparam int CFG_W  = 21;
  localparam int CIDX_W = 2;

  // Parameter defaults.
  localparam int SLOT_COUNT_DEF   = 32;
  localparam int FREE_ENTRIES_DEF = 33;
  localparam int ADDR_BITS_DEF    = 20;

  // Register reset values.
  localparam logic [LEN_W-1:0]  RAM_SIZE_RST    = LEN_W'(65536);
  localparam logic [ADDR_W-1:0] BASE_OFFSET_RST = '0;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    REG_RAM_SIZE    = 2'd0,
    REG_BASE_OFFSET = 2'd1
  } reg_idx_t;

  // Request modes.
  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FIT   = 2'd1,
    STAT_NO_SLOT  = 2'd2,
    STAT_NOT_LIVE = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SLOT_RD,
    ST_SCAN,
    ST_UPDATE,
    ST_MAX,
    ST_RESULT
  } state_t;

  // What the shared scan unit looks for.
  typedef enum logic [1:0] {
    OP_BEST,
    OP_MERGE,
    OP_MAX
  } scan_op_t;

  // One segment: start address and length (addresses held at LEN_W bits).
  typedef struct packed {
    logic [LEN_W-1:0] addr;
    logic [LEN_W-1:0] len;
  } seg_t;

  // Scan control from the sequencer.
  typedef struct packed {
    logic     clr;
    scan_op_t op;
    logic     ent_vld;
  } scan_ctl_t;

  // Scan status back to the sequencer.
  typedef struct packed {
    logic best_found;
    logic left_found;
    logic right_found;
    logic empty_found;
  } scan_flags_t;

endpackage

/* rtl/bfa_ram.sv */
// ----------------------------------------------------------------------------
// Allocator table RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int DEPTH = bfa_pkg::FREE_ENTRIES_DEF,
  parameter int WIDTH = $bits(bfa_pkg::seg_t)
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bfa_scan.sv */
// ----------------------------------------------------------------------------
// Allocator scan unit
// Shared compare unit that walks the free table one entry per cycle.
// ----------------------------------------------------------------------------
module bfa_scan #(
  parameter int FREE_ENTRIES = bfa_pkg::FREE_ENTRIES_DEF,
  localparam int FIDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bfa_pkg::scan_ctl_t      ctl,
  input  logic [FIDX_W-1:0]       ent_idx,
  input  logic                    ent_valid,
  input  bfa_pkg::seg_t           ent,
  input  logic [bfa_pkg::LEN_W-1:0] key_size,
  input  logic [bfa_pkg::LEN_W-1:0] key_addr,
  input  logic [bfa_pkg::LEN_W:0]   key_end,
  output bfa_pkg::scan_flags_t    flags,
  output logic [FIDX_W-1:0]       best_idx,
  output bfa_pkg::seg_t           best_seg,
  output logic [FIDX_W-1:0]       left_idx,
  output bfa_pkg::seg_t           left_seg,
  output logic [FIDX_W-1:0]       right_idx,
  output logic [bfa_pkg::LEN_W-1:0] right_len,
  output logic [FIDX_W-1:0]       empty_idx,
  output logic [bfa_pkg::LEN_W-1:0] max_len
);

  bfa_pkg::scan_flags_t flags_r;
  logic [FIDX_W-1:0]    best_idx_r, left_idx_r, right_idx_r, empty_idx_r;
  bfa_pkg::seg_t        best_seg_r, left_seg_r;
  logic [bfa_pkg::LEN_W-1:0] right_len_r, max_len_r;

  logic [bfa_pkg::LEN_W:0] ent_end;
  logic fits, better, is_left, is_right;

  // Shared adder and comparators.
  always_comb begin
    ent_end  = {1'b0, ent.addr} + {1'b0, ent.len};
    fits     = ent.len >= key_size;
    better   = !flags_r.best_found || (ent.len < best_seg_r.len) ||
               ((ent.len == best_seg_r.len) && (ent.addr < best_seg_r.addr));
    is_left  = ent_end == {1'b0, key_addr};
    is_right = {1'b0, ent.addr} == key_end;
  end

  // Accumulate the scan results.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      flags_r   <= '0;
      max_len_r <= '0;
    end else if (ctl.ent_vld) begin
      case (ctl.op)
        bfa_pkg::OP_BEST: begin
          if (ent_valid && fits && better) begin
            flags_r.best_found <= 1'b1;
            best_idx_r         <= ent_idx;
            best_seg_r         <= ent;
          end
        end
        bfa_pkg::OP_MERGE: begin
          if (ent_valid && is_left) begin
            flags_r.left_found <= 1'b1;
            left_idx_r         <= ent_idx;
            left_seg_r         <= ent;
          end else if (ent_valid && is_right) begin
            flags_r.right_found <= 1'b1;
            right_idx_r         <= ent_idx;
            right_len_r         <= ent.len;
          end
          if (!ent_valid && !flags_r.empty_found) begin
            flags_r.empty_found <= 1'b1;
            empty_idx_r         <= ent_idx;
          end
        end
        default: begin
          if (ent_valid && (ent.len > max_len_r)) begin
            max_len_r <= ent.len;
          end
        end
      endcase
    end
  end

  assign flags     = flags_r;
  assign best_idx  = best_idx_r;
  assign best_seg  = best_seg_r;
  assign left_idx  = left_idx_r;
  assign left_seg  = left_seg_r;
  assign right_idx = right_idx_r;
  assign right_len = right_len_r;
  assign empty_idx = empty_idx_r;
  assign max_len   = max_len_r;

endmodule

/* rtl/best_fit_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// Best-fit block allocator
// Free-segment and slot tables with best-fit allocation and coalescing free.
// ----------------------------------------------------------------------------
// Usage: raise start with in_mode, in_req_size and in_slot while busy is low;
// the request is taken at that edge and busy rises. An allocate request takes
// the smallest fitting free segment (lowest address on a tie) and the lowest
// clear slot; a free request returns a live slot's block and merges it with
// free neighbors. Each request gives one result, shown for exactly one cycle
// with out_valid high; the receiver cannot stall it. busy falls in the cycle
// after the result.
// Allocate and a successful free each make two passes of the shared scan unit
// over the free table RAM, one read a cycle: one to search, one for the largest
// free segment after the update. A failed free makes only the latter pass.
// Reset and every write to an existing configuration register re-initialize
// both tables, with busy high in the init state.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_top #(
  parameter int SLOT_COUNT   = bfa_pkg::SLOT_COUNT_DEF,
  parameter int FREE_ENTRIES = bfa_pkg::FREE_ENTRIES_DEF,
  parameter int ADDR_BITS    = bfa_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Request channel.
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [bfa_pkg::LEN_W-1:0]    in_req_size,
  input  logic [bfa_pkg::SLOT_W-1:0]   in_slot,
  // Result channel.
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [bfa_pkg::SLOT_W-1:0]   out_slot_used,
  output logic [bfa_pkg::ADDR_W-1:0]   out_block_addr,
  output logic [bfa_pkg::LEN_W-1:0]    out_block_size,
  output logic [bfa_pkg::LEN_W-1:0]    out_largest_free,
  output logic [bfa_pkg::LEN_W-1:0]    out_used_total,
  // Configuration port.
  input  logic                         cfg_we,
  input  logic [bfa_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bfa_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int LW     = bfa_pkg::LEN_W;
  localparam int FIDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SCAN_N = (FREE_ENTRIES > SLOT_COUNT) ? FREE_ENTRIES : SLOT_COUNT;
  localparam int CNT_W  = $clog2(SCAN_N + 1);
  localparam logic [32:0] LIMIT = 33'(1) << ADDR_BITS;

  // Configuration registers.
  logic [LW-1:0]             ram_size_r;
  logic [bfa_pkg::ADDR_W-1:0] base_r;

  bfa_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              ent_vld_r;
  logic [FIDX_W-1:0] ent_idx_r;

  // Request registers.
  logic                       mode_r;
  logic [LW-1:0]              size_r;
  logic [bfa_pkg::SLOT_W-1:0] sidx_r;
  logic [LW-1:0]              key_addr_r;
  logic [LW:0]                key_end_r;
  logic                       slot_found_r;
  logic [SIDX_W-1:0]          slot_sel_r;

  // Table state.
  logic [FREE_ENTRIES-1:0] fv_r;
  logic [SLOT_COUNT-1:0]   sv_r;
  logic [LW-1:0]           used_r;

  // Result registers.
  bfa_pkg::status_t           st_r;
  logic [bfa_pkg::SLOT_W-1:0] oslot_r;
  logic [LW-1:0]              oaddr_r;
  logic [LW-1:0]              osize_r;

  // RAM ports.
  logic              fwe;
  logic [FIDX_W-1:0] fwaddr;
  bfa_pkg::seg_t     fwdata, frdata;
  logic              swe;
  logic [SIDX_W-1:0] swaddr, sraddr;
  bfa_pkg::seg_t     swdata, srdata;

  // Scan unit.
  bfa_pkg::scan_ctl_t   sctl;
  bfa_pkg::scan_flags_t sflags;
  logic [FIDX_W-1:0]    best_idx, left_idx, right_idx, empty_idx;
  bfa_pkg::seg_t        best_seg, left_seg;
  logic [LW-1:0]        right_len, max_len;

  logic accept, in_range, slot_live, alloc_ok, scan_done, cfg_hit;
  logic [SIDX_W-1:0] in_sidx;
  logic [32:0] lo33, hi33;
  bfa_pkg::seg_t init_seg;

  assign accept    = start && (state_r == bfa_pkg::ST_IDLE);
  assign in_sidx   = SIDX_W'(in_slot);
  assign in_range  = 7'(in_slot) < 7'(SLOT_COUNT);
  assign slot_live = in_range && sv_r[in_sidx];
  assign scan_done = cnt_r == CNT_W'(SCAN_N);
  assign alloc_ok  = (size_r != '0) && slot_found_r && sflags.best_found;

  // Only a write to an existing register re-initializes the tables.
  assign cfg_hit   = cfg_we && ((cfg_index == bfa_pkg::REG_RAM_SIZE) ||
                                (cfg_index == bfa_pkg::REG_BASE_OFFSET));

  // Initial free segment from the clamped range.
  always_comb begin
    lo33 = (33'(base_r) < LIMIT) ? 33'(base_r) : LIMIT;
    hi33 = (33'(ram_size_r) < LIMIT) ? 33'(ram_size_r) : LIMIT;
    init_seg.addr = lo33[LW-1:0];
    init_seg.len  = (hi33 > lo33) ? LW'(hi33 - lo33) : '0;
  end

  // Next state and scan control.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfa_pkg::ST_INIT:    state_nxt = bfa_pkg::ST_IDLE;
      bfa_pkg::ST_IDLE: begin
        if (start) begin
          if (in_mode == bfa_pkg::MODE_ALLOC) state_nxt = bfa_pkg::ST_SCAN;
          else if (slot_live)                 state_nxt = bfa_pkg::ST_SLOT_RD;
          else                                state_nxt = bfa_pkg::ST_MAX;
        end
      end
      bfa_pkg::ST_SLOT_RD: state_nxt = bfa_pkg::ST_SCAN;
      bfa_pkg::ST_SCAN:    if (scan_done) state_nxt = bfa_pkg::ST_UPDATE;
      bfa_pkg::ST_UPDATE:  state_nxt = bfa_pkg::ST_MAX;
      bfa_pkg::ST_MAX:     if (scan_done) state_nxt = bfa_pkg::ST_RESULT;
      bfa_pkg::ST_RESULT:  state_nxt = bfa_pkg::ST_IDLE;
      default:             state_nxt = bfa_pkg::ST_INIT;
    endcase
    if (cfg_hit) state_nxt = bfa_pkg::ST_INIT;

    sctl.clr     = (state_nxt != state_r) &&
                   ((state_nxt == bfa_pkg::ST_SCAN) || (state_nxt == bfa_pkg::ST_MAX));
    sctl.op      = (state_r == bfa_pkg::ST_MAX) ? bfa_pkg::OP_MAX :
                   (mode_r == bfa_pkg::MODE_ALLOC) ? bfa_pkg::OP_BEST : bfa_pkg::OP_MERGE;
    sctl.ent_vld = ent_vld_r;
  end

  // State register and scan counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bfa_pkg::ST_INIT;
      cnt_r     <= '0;
      ent_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ent_vld_r <= ((state_r == bfa_pkg::ST_SCAN) || (state_r == bfa_pkg::ST_MAX)) &&
                   (cnt_r < CNT_W'(FREE_ENTRIES));
      ent_idx_r <= cnt_r[FIDX_W-1:0];
      if (state_nxt != state_r) cnt_r <= '0;
      else                      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_size_r <= bfa_pkg::RAM_SIZE_RST;
      base_r     <= bfa_pkg::BASE_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfa_pkg::REG_RAM_SIZE:    ram_size_r <= cfg_wdata;
        bfa_pkg::REG_BASE_OFFSET: base_r     <= cfg_wdata[bfa_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Table writes for init and update.
  always_comb begin
    fwe    = 1'b0;
    fwaddr = '0;
    fwdata = init_seg;
    swe    = 1'b0;
    swaddr = slot_sel_r;
    swdata.addr = best_seg.addr;
    swdata.len  = size_r;
    if (state_r == bfa_pkg::ST_INIT) begin
      fwe = 1'b1;
    end else if (state_r == bfa_pkg::ST_UPDATE) begin
      if (mode_r == bfa_pkg::MODE_ALLOC) begin
        fwe         = alloc_ok && (best_seg.len != size_r);
        swe         = alloc_ok;
        fwaddr      = best_idx;
        fwdata.addr = best_seg.addr + size_r;
        fwdata.len  = best_seg.len - size_r;
      end else if (sflags.left_found) begin
        fwe         = 1'b1;
        fwaddr      = left_idx;
        fwdata.addr = left_seg.addr;
        fwdata.len  = left_seg.len + size_r + (sflags.right_found ? right_len : '0);
      end else if (sflags.right_found) begin
        fwe         = 1'b1;
        fwaddr      = right_idx;
        fwdata.addr = key_addr_r;
        fwdata.len  = right_len + size_r;
      end else begin
        fwe         = sflags.empty_found;
        fwaddr      = empty_idx;
        fwdata.addr = key_addr_r;
        fwdata.len  = size_r;
      end
    end
    sraddr = in_sidx;
  end

  // Request, valid bits, running total and result fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r   <= '0;
      sv_r   <= '0;
      used_r <= '0;
    end else begin
      unique case (state_r)
        bfa_pkg::ST_INIT: begin
          fv_r    <= {{(FREE_ENTRIES-1){1'b0}}, (init_seg.len != '0)};
          sv_r    <= '0;
          used_r  <= '0;
        end
        bfa_pkg::ST_IDLE: begin
          if (accept) begin
            mode_r       <= in_mode;
            size_r       <= in_req_size;
            sidx_r       <= in_slot;
            slot_found_r <= 1'b0;
            oslot_r      <= (in_mode == bfa_pkg::MODE_FREE) ? in_slot : '0;
            oaddr_r      <= '0;
            osize_r      <= '0;
            st_r         <= (in_mode == bfa_pkg::MODE_FREE && !slot_live) ?
                            bfa_pkg::STAT_NOT_LIVE : bfa_pkg::STAT_OK;
          end
        end
        bfa_pkg::ST_SLOT_RD: begin
          size_r       <= srdata.len;
          key_addr_r   <= srdata.addr;
          key_end_r    <= {1'b0, srdata.addr} + {1'b0, srdata.len};
          oaddr_r      <= srdata.addr;
          osize_r      <= srdata.len;
          sv_r[SIDX_W'(sidx_r)] <= 1'b0;
          used_r       <= used_r - srdata.len;
        end
        bfa_pkg::ST_SCAN: begin
          // Lowest clear slot, found alongside the free-table pass.
          if ((cnt_r < CNT_W'(SLOT_COUNT)) && !slot_found_r &&
              !sv_r[cnt_r[SIDX_W-1:0]]) begin
            slot_found_r <= 1'b1;
            slot_sel_r   <= cnt_r[SIDX_W-1:0];
          end
        end
        bfa_pkg::ST_UPDATE: begin
          if (mode_r == bfa_pkg::MODE_ALLOC) begin
            if (size_r == '0)             st_r <= bfa_pkg::STAT_NO_FIT;
            else if (!slot_found_r)       st_r <= bfa_pkg::STAT_NO_SLOT;
            else if (!sflags.best_found)  st_r <= bfa_pkg::STAT_NO_FIT;
            if (alloc_ok) begin
              oslot_r            <= bfa_pkg::SLOT_W'(slot_sel_r);
              oaddr_r            <= best_seg.addr;
              osize_r            <= size_r;
              sv_r[slot_sel_r]   <= 1'b1;
              used_r             <= used_r + size_r;
              if (best_seg.len == size_r) fv_r[best_idx] <= 1'b0;
            end
          end else if (sflags.left_found) begin
            if (sflags.right_found) fv_r[right_idx] <= 1'b0;
          end else if (!sflags.right_found && sflags.empty_found) begin
            fv_r[empty_idx] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Free segment table.
  bfa_ram #(.DEPTH(FREE_ENTRIES), .WIDTH($bits(bfa_pkg::seg_t))) u_free_ram (
    .clk   (clk),
    .we    (fwe),
    .waddr (fwaddr),
    .wdata (fwdata),
    .raddr (cnt_r[FIDX_W-1:0]),
    .rdata (frdata)
  );

  // Live block table.
  bfa_ram #(.DEPTH(SLOT_COUNT), .WIDTH($bits(bfa_pkg::seg_t))) u_slot_ram (
    .clk   (clk),
    .we    (swe),
    .waddr (swaddr),
    .wdata (swdata),
    .raddr (sraddr),
    .rdata (srdata)
  );

  // Shared scan unit.
  bfa_scan #(.FREE_ENTRIES(FREE_ENTRIES)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sctl),
    .ent_idx   (ent_idx_r),
    .ent_valid (fv_r[ent_idx_r]),
    .ent       (frdata),
    .key_size  (size_r),
    .key_addr  (key_addr_r),
    .key_end   (key_end_r),
    .flags     (sflags),
    .best_idx  (best_idx),
    .best_seg  (best_seg),
    .left_idx  (left_idx),
    .left_seg  (left_seg),
    .right_idx (right_idx),
    .right_len (right_len),
    .empty_idx (empty_idx),
    .max_len   (max_len)
  );

  // Result ports.
  assign busy             = state_r != bfa_pkg::ST_IDLE;
  assign out_valid        = state_r == bfa_pkg::ST_RESULT;
  assign out_status       = st_r;
  assign out_slot_used    = oslot_r;
  assign out_block_addr   = oaddr_r[bfa_pkg::ADDR_W-1:0];
  assign out_block_size   = osize_r;
  assign out_largest_free = max_len;
  assign out_used_total   = used_r;

endmodule

/* rtl/bfa_checker.sv */
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the top-level ports for request and result sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [bfa_pkg::LEN_W-1:0] out_block_size,
  input logic       cfg_we,
  input logic [bfa_pkg::CIDX_W-1:0] cfg_index
);

  // A result only appears while a request is in progress.
  `BFA_ASSERT(a_result_busy, out_valid |-> busy, "result shown while not busy")

  // A taken request makes the block busy.
  `BFA_ASSERT(a_take_busy, (start && !busy) |=> busy, "request taken but block not busy")

  // Each result lasts exactly one cycle.
  `BFA_ASSERT(a_one_cycle, out_valid |=> !out_valid, "result held for two cycles")

  // A refused free reports no block.
  `BFA_ASSERT(a_not_live_zero,
    (out_valid && out_status == bfa_pkg::STAT_NOT_LIVE) |-> (out_block_size == '0),
    "refused free reports a block size")

  // A write to an existing register re-initializes the tables.
  `BFA_ASSERT_ALWAYS(a_cfg_init, (rst_n && cfg_we && (cfg_index == bfa_pkg::REG_RAM_SIZE || cfg_index == bfa_pkg::REG_BASE_OFFSET)) |=> busy, "no re-init after register write")

endmodule

bind best_fit_block_allocator_top bfa_checker u_bfa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_block_size (out_block_size),
  .cfg_we         (cfg_we),
  .cfg_index      (cfg_index)
);
